[rtl/sem_pkg.sv]
package sem_pkg;

  localparam int PIX_W     = 8;
  localparam int ROW_W     = 11;
  localparam int COL_W     = 11;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_FIRST_ROW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_END_ROW   = 2'd3;

  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = 12'd640;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = 12'd480;
  localparam logic [ROW_W-1:0] RST_BAND_FIRST_ROW = 11'd0;
  localparam logic [CFG_W-1:0] RST_BAND_END_ROW   = 12'd480;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;
  localparam logic [CFG_W-1:0] ROW_SAT = 12'd4095;

  localparam int OUTQ_DEPTH = 4;

  // 3x3 window, [row top..bottom][column left..right]
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [PIX_W-1:0] mag;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             eob;
  } result_t;

endpackage

[rtl/sem_ram.sv]
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/sem_kernel.sv]
module sem_kernel (
  input  sem_pkg::win_t                win_i,
  output logic [sem_pkg::PIX_W-1:0]    mag_o
);

  logic [9:0]        x_right, x_left, y_bot, y_top;
  logic signed [10:0] gx, gy;
  logic [9:0]        ax, ay;
  logic [10:0]       sum;

  always_comb begin
    x_right = 10'(win_i[0][2]) + {1'b0, win_i[1][2], 1'b0} + 10'(win_i[2][2]);
    x_left  = 10'(win_i[0][0]) + {1'b0, win_i[1][0], 1'b0} + 10'(win_i[2][0]);
    y_bot   = 10'(win_i[2][0]) + {1'b0, win_i[2][1], 1'b0} + 10'(win_i[2][2]);
    y_top   = 10'(win_i[0][0]) + {1'b0, win_i[0][1], 1'b0} + 10'(win_i[0][2]);
    gx      = $signed({1'b0, x_right}) - $signed({1'b0, x_left});
    gy      = $signed({1'b0, y_bot}) - $signed({1'b0, y_top});
    ax      = gx[10] ? 10'(-gx) : 10'(gx);
    ay      = gy[10] ? 10'(-gy) : 10'(gy);
    sum     = 11'(ax) + 11'(ay);
    mag_o   = (sum > 11'(sem_pkg::MAG_MAX)) ? sem_pkg::MAG_MAX : sum[7:0];
  end

endmodule

[rtl/sem_outq.sv]
module sem_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push0_i,
  input  sem_pkg::result_t  data0_i,
  input  logic              push1_i,
  input  sem_pkg::result_t  data1_i,
  output logic              room2_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sem_pkg::result_t  out_data_o
);

  localparam int PW   = $clog2(sem_pkg::OUTQ_DEPTH);
  localparam int CNTW = $clog2(sem_pkg::OUTQ_DEPTH + 1);

  sem_pkg::result_t entry_q [sem_pkg::OUTQ_DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d, cnt_left;
  logic             pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = entry_q[rptr_q];
  assign cnt_left    = cnt_q - CNTW'(pop);
  assign room2_o     = (cnt_left <= CNTW'(sem_pkg::OUTQ_DEPTH - 2));

  always_comb begin
    wptr_d = wptr_q + PW'(push0_i) + PW'(push1_i);
    rptr_d = rptr_q + PW'(pop);
    cnt_d  = cnt_left + CNTW'(push0_i) + CNTW'(push1_i);
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      entry_q[wptr_q] <= data0_i;
    end
    if (push1_i) begin
      entry_q[wptr_q + PW'(1)] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[rtl/sobel_edge_magnitude.sv]
// Sobel 3x3 edge magnitude over a raster-order stream of red pixel bytes.
// Input channel (in_valid_i/in_ready_o): one word per pixel, command_i 0 for
// an image pixel, 1 for a flush tick; a flush row after the last image row
// drains the bottom row. Results (out_valid_o/out_ready_i) carry |gx|+|gy|
// saturated at 255 with row and column; the pixel at (r,c) yields the result
// for (r-1,c-1), and the last column also yields (r-1,W-1), so one word in
// gives zero, one or two words out. Only rows inside the band are emitted.
// Configuration is written through cfg_valid_i/cfg_index_i/cfg_data_i, always
// ready; the user must write it only while the block holds no word in flight;
// the block does not enforce this. Throughput: one pixel per clock while the
// result queue has room. The two line stores are single-write, single-read
// RAMs read once and written once per pixel; a pixel's read is issued as it
// is accepted and its write-back happens as it leaves stage a, with a forward
// path for back-to-back hits on one column. A four-word result queue
// decouples the receiver: while it stalls, input keeps flowing until the
// queue cannot take two more words. Rows that emit two words per pixel at
// the end of a line drain at one word per cycle while the receiver is ready.
// Reset returns the registers to their defaults and the position to row 0,
// column 0; the line stores need no clearing.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sem_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sem_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic [sem_pkg::PIX_W-1:0]         pixel_red_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sem_pkg::PIX_W-1:0]         magnitude_o,
  output logic [sem_pkg::ROW_W-1:0]         out_row_o,
  output logic [sem_pkg::COL_W-1:0]         out_col_o,
  output logic                              last_of_item_o,
  output logic                              end_of_band_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PX = sem_pkg::PIX_W;
  localparam int RW = sem_pkg::CFG_W;

  // configuration
  logic [RW-1:0]               image_width_q, image_height_q, band_end_row_q;
  logic [sem_pkg::ROW_W-1:0]   band_first_row_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q    <= sem_pkg::RST_IMAGE_WIDTH;
      image_height_q   <= sem_pkg::RST_IMAGE_HEIGHT;
      band_first_row_q <= sem_pkg::RST_BAND_FIRST_ROW;
      band_end_row_q   <= sem_pkg::RST_BAND_END_ROW;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sem_pkg::CFG_IMAGE_WIDTH:    image_width_q    <= cfg_data_i;
        sem_pkg::CFG_IMAGE_HEIGHT:   image_height_q   <= cfg_data_i;
        sem_pkg::CFG_BAND_FIRST_ROW: band_first_row_q <= cfg_data_i[sem_pkg::ROW_W-1:0];
        sem_pkg::CFG_BAND_END_ROW:   band_end_row_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic en, accept, wr_en, room2;
  logic a_valid_q, b_valid_q;

  assign en         = !b_valid_q || room2;
  assign in_ready_o = !a_valid_q || en;
  assign accept     = in_valid_i && in_ready_o;
  assign wr_en      = a_valid_q && en;

  // position and per-pixel decode at accept
  logic [CW-1:0]   col_q, col_d, c, wm1;
  logic [RW-1:0]   row_q, row_d, rr, band_end;
  logic [31:0]     wm1_full, c_ext;
  logic            is_last, row_ok, emit1, emit2, eob;
  logic [PX-1:0]   pix;

  always_comb begin
    if (image_width_q == '0) begin
      wm1_full = '0;
    end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
      wm1_full = 32'(MAX_WIDTH) - 32'd1;
    end else begin
      wm1_full = 32'(image_width_q) - 32'd1;
    end
    wm1      = wm1_full[CW-1:0];
    c        = (col_q > wm1) ? wm1 : col_q;
    c_ext    = 32'(c);
    is_last  = (c == wm1);
    pix      = (command_i == sem_pkg::CMD_FLUSH || row_q >= image_height_q) ? '0 : pixel_red_i;
    rr       = row_q - RW'(1);
    band_end = (band_end_row_q < image_height_q) ? band_end_row_q : image_height_q;
    row_ok   = (row_q != '0) && (rr < image_height_q) &&
               (rr >= RW'(band_first_row_q)) && (rr < band_end);
    emit1    = row_ok && (c != '0);
    emit2    = row_ok && is_last;
    eob      = (rr == band_end - RW'(1));

    col_d = col_q;
    row_d = row_q;
    if (is_last) begin
      col_d = '0;
      if (command_i == sem_pkg::CMD_FLUSH) begin
        row_d = '0;
      end else if (row_q < sem_pkg::ROW_SAT) begin
        row_d = row_q + RW'(1);
      end
    end else begin
      col_d = c + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage a: line store read in flight
  logic [CW-1:0]             a_c_q;
  logic [PX-1:0]             a_p_q, a_fwd_up_q, a_fwd_mid_q;
  logic                      a_r1_q, a_r2_q, a_c0_q, a_fwd_q;
  logic                      a_emit1_q, a_emit2_q, a_eob_q;
  logic [sem_pkg::ROW_W-1:0] a_row_q;
  logic [sem_pkg::COL_W-1:0] a_col1_q, a_col2_q;
  logic [PX-1:0]             up_rdata, mid_rdata, up_raw, mid_raw, top_px, mid_px;

  // forward when the read in flight was issued in the cycle its column was written
  assign mid_raw = a_fwd_q ? a_fwd_mid_q : mid_rdata;
  assign up_raw  = a_fwd_q ? a_fwd_up_q : up_rdata;
  assign top_px  = a_r2_q ? up_raw : '0;
  assign mid_px  = a_r1_q ? mid_raw : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (en) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_c_q       <= c;
      a_p_q       <= pix;
      a_r1_q      <= (row_q >= RW'(1));
      a_r2_q      <= (row_q >= RW'(2));
      a_c0_q      <= (c == '0);
      a_emit1_q   <= emit1;
      a_emit2_q   <= emit2;
      a_eob_q     <= eob;
      a_row_q     <= rr[sem_pkg::ROW_W-1:0];
      a_col1_q    <= sem_pkg::COL_W'(c_ext - 32'd1);
      a_col2_q    <= sem_pkg::COL_W'(wm1_full);
      a_fwd_q     <= wr_en && (a_c_q == c);
      a_fwd_up_q  <= mid_raw;
      a_fwd_mid_q <= a_p_q;
    end
  end

  sem_ram #(
    .WIDTH (PX),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (a_c_q),
    .wdata_i (mid_raw),
    .re_i    (accept),
    .raddr_i (c),
    .rdata_o (up_rdata)
  );

  sem_ram #(
    .WIDTH (PX),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (a_c_q),
    .wdata_i (a_p_q),
    .re_i    (accept),
    .raddr_i (c),
    .rdata_o (mid_rdata)
  );

  // window shift, stage b
  sem_pkg::win_t             win_q, win_b;
  logic                      b_emit1_q, b_emit2_q, b_eob_q;
  logic [sem_pkg::ROW_W-1:0] b_row_q;
  logic [sem_pkg::COL_W-1:0] b_col1_q, b_col2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= a_valid_q;
      if (a_valid_q) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= a_c0_q ? '0 : win_q[i][1];
          win_q[i][1] <= a_c0_q ? '0 : win_q[i][2];
        end
        win_q[0][2] <= top_px;
        win_q[1][2] <= mid_px;
        win_q[2][2] <= a_p_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      b_emit1_q <= a_emit1_q;
      b_emit2_q <= a_emit2_q;
      b_eob_q   <= a_eob_q;
      b_row_q   <= a_row_q;
      b_col1_q  <= a_col1_q;
      b_col2_q  <= a_col2_q;
    end
  end

  // right-edge result uses the two newest columns and a zero column beyond
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_b[i][0] = win_q[i][1];
      win_b[i][1] = win_q[i][2];
      win_b[i][2] = '0;
    end
  end

  logic [PX-1:0]    mag_a, mag_b;
  sem_pkg::result_t res1, res2, slot0;
  logic             push, push0, push1;

  sem_kernel u_kernel_a (
    .win_i (win_q),
    .mag_o (mag_a)
  );

  sem_kernel u_kernel_b (
    .win_i (win_b),
    .mag_o (mag_b)
  );

  always_comb begin
    res1  = '{mag: mag_a, row: b_row_q, col: b_col1_q, last: !b_emit2_q, eob: 1'b0};
    res2  = '{mag: mag_b, row: b_row_q, col: b_col2_q, last: 1'b1, eob: b_eob_q};
    slot0 = b_emit1_q ? res1 : res2;
    push  = en && b_valid_q;
    push0 = push && (b_emit1_q || b_emit2_q);
    push1 = push && b_emit1_q && b_emit2_q;
  end

  sem_pkg::result_t out_data;

  sem_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push0_i     (push0),
    .data0_i     (slot0),
    .push1_i     (push1),
    .data1_i     (res2),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign magnitude_o    = out_data.mag;
  assign out_row_o      = out_data.row;
  assign out_col_o      = out_data.col;
  assign last_of_item_o = out_data.last;
  assign end_of_band_o  = out_data.eob;

endmodule

[rtl/sem_chk.sv]
module sem_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [sem_pkg::PIX_W-1:0]   magnitude_o,
  input logic [sem_pkg::ROW_W-1:0]   out_row_o,
  input logic [sem_pkg::COL_W-1:0]   out_col_o,
  input logic                        last_of_item_o,
  input logic                        end_of_band_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(magnitude_o) &&
      $stable(out_row_o) && $stable(out_col_o) && $stable(last_of_item_o) &&
      $stable(end_of_band_o))
    else $error("result word changed while stalled");

  // band end only on the closing word of a pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_band_o |-> last_of_item_o)
    else $error("end of band on a word that is not last");

  // the first of a pair is followed at once by its right neighbor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_item_o |=>
      out_valid_o && out_row_o == $past(out_row_o) &&
      out_col_o == $past(out_col_o) + 11'd1)
    else $error("second word of a pair missing or misplaced");

endmodule

bind sobel_edge_magnitude sem_chk u_sem_chk (.*);

[test/sobel_edge_check_pkg.sv]
`timescale 1ns / 1ps
package sobel_edge_check_pkg;
  import sem_pkg::*;

  localparam int LINE_DEPTH = 2048;

  class edge_scoreboard;
    logic [CFG_W-1:0] img_width;
    logic [CFG_W-1:0] img_height;
    logic [ROW_W-1:0] band_first;
    logic [CFG_W-1:0] band_end;
    logic [PIX_W-1:0] upper_line[LINE_DEPTH];
    logic [PIX_W-1:0] middle_line[LINE_DEPTH];
    logic [PIX_W-1:0] win[3][3];
    int col_pos;
    int row_pos;
    result_t pending[$];
    int fails;

    function new();
      img_width  = RST_IMAGE_WIDTH;
      img_height = RST_IMAGE_HEIGHT;
      band_first = RST_BAND_FIRST_ROW;
      band_end   = RST_BAND_END_ROW;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_pos = 0;
      row_pos = 0;
      fails   = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:    img_width = data;
        CFG_IMAGE_HEIGHT:   img_height = data;
        CFG_BAND_FIRST_ROW: band_first = data[ROW_W-1:0];
        CFG_BAND_END_ROW:   band_end = data;
        default: ;
      endcase
    endfunction

    // window columns a, b, cc feed the left, center and right kernel taps
    function logic [PIX_W-1:0] grad_mag(int a, int b, int cc, bit right_zero);
      int px[3][3];
      int gx;
      int gy;
      int m;
      int i;
      for (i = 0; i < 3; i++) begin
        px[i][0] = win[i][a];
        px[i][1] = win[i][b];
        px[i][2] = right_zero ? 0 : int'(win[i][cc]);
      end
      gx = (px[0][2] + 2 * px[1][2] + px[2][2]) - (px[0][0] + 2 * px[1][0] + px[2][0]);
      gy = (px[2][0] + 2 * px[2][1] + px[2][2]) - (px[0][0] + 2 * px[0][1] + px[0][2]);
      m = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      return (m > MAG_MAX) ? MAG_MAX : PIX_W'(m);
    endfunction

    function void note_word(logic cmd, logic [PIX_W-1:0] red);
      int w;
      int c;
      int r;
      int rr;
      int stop_row;
      int n;
      int i;
      logic [PIX_W-1:0] p;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      result_t res[2];
      w = img_width;
      if (w < 1) w = 1;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      c = col_pos;
      if (c >= w) c = w - 1;
      r = row_pos;
      p = (cmd == CMD_FLUSH || r >= img_height) ? '0 : red;
      top = (r >= 2) ? upper_line[c] : '0;
      mid = (r >= 1) ? middle_line[c] : '0;
      for (i = 0; i < 3; i++) begin
        if (c == 0) begin
          win[i][0] = '0;
          win[i][1] = '0;
        end else begin
          win[i][0] = win[i][1];
          win[i][1] = win[i][2];
        end
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = p;
      upper_line[c]  = middle_line[c];
      middle_line[c] = p;

      stop_row = (band_end < img_height) ? int'(band_end) : int'(img_height);
      n = 0;
      rr = r - 1;
      if (r >= 1 && rr < img_height && rr >= band_first && rr < stop_row) begin
        if (c >= 1) begin
          res[n] = '{mag: grad_mag(0, 1, 2, 1'b0), row: ROW_W'(rr), col: COL_W'(c - 1),
                     last: 1'b0, eob: 1'b0};
          n++;
        end
        // right border pixel of the row, right neighbours are outside
        if (c == w - 1) begin
          res[n] = '{mag: grad_mag(1, 2, 0, 1'b1), row: ROW_W'(rr), col: COL_W'(w - 1),
                     last: 1'b0, eob: (rr == stop_row - 1)};
          n++;
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (i = 0; i < n; i++) pending.push_back(res[i]);
      end

      if (c == w - 1) begin
        col_pos = 0;
        if (cmd == CMD_FLUSH) row_pos = 0;
        else if (r < ROW_SAT) row_pos = r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    task report(string msg);
      if (fails < 40) $display("%0t mismatch: %s", $time, msg);
      fails++;
    endtask

    task compare_field(string name, int got, int want, result_t ref_word);
      if (got !== want)
        report($sformatf("%s got %0d want %0d (pixel row %0d col %0d)",
                         name, got, want, ref_word.row, ref_word.col));
    endtask

    task check_word(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word mag %0d row %0d col %0d",
                         got.mag, got.row, got.col));
        return;
      end
      want = pending.pop_front();
      if (^got === 1'bx) report("word carries unknown bits");
      compare_field("magnitude", got.mag, want.mag, want);
      compare_field("out_row", got.row, want.row, want);
      compare_field("out_col", got.col, want.col, want);
      compare_field("last_of_item", got.last, want.last, want);
      compare_field("end_of_band", got.eob, want.eob, want);
    endtask

    function bit busy();
      return pending.size() != 0;
    endfunction
  endclass

endpackage

[test/tb_sobel_edge_magnitude.sv]
`timescale 1ns / 1ps
module tb_sobel_edge_magnitude;
  import sem_pkg::*;
  import sobel_edge_check_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS  = 600;
  localparam int CALM_ITEMS    = 150;

  typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_CHECKER} fill_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 command_i   = CMD_PIXEL;
  logic [PIX_W-1:0]     pixel_red_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [PIX_W-1:0]     magnitude_o;
  logic [ROW_W-1:0]     out_row_o;
  logic [COL_W-1:0]     out_col_o;
  logic                 last_of_item_o;
  logic                 end_of_band_o;

  edge_scoreboard sb = new();
  bit gaps_on = 1'b1;
  int hold_len = 0;
  int items_sent = 0;

  sobel_edge_magnitude #(.MAX_WIDTH(LINE_DEPTH)) dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("** sobel_edge_magnitude: FAILED **");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int n;
    @(posedge clk_i);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_word({magnitude_o, out_row_o, out_col_o, last_of_item_o, end_of_band_o});
  end

  task automatic push_word(logic cmd, logic [PIX_W-1:0] red);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    pixel_red_i <= red;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(cmd, red);
    items_sent++;
  endtask

  // wait until every expected word is out and the pipe is quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.busy()) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.apply_reg(idx, CFG_W'(value));
  endtask

  task automatic set_geometry(int w_cfg, int h, int bf, int be);
    cfg_beat(CFG_IMAGE_WIDTH, w_cfg);
    cfg_beat(CFG_IMAGE_HEIGHT, h);
    cfg_beat(CFG_BAND_FIRST_ROW, bf);
    cfg_beat(CFG_BAND_END_ROW, be);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] pick_red(fill_e fill, int row, int col);
    case (fill)
      FILL_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
      FILL_CHECKER: return ((row + col) % 2) ? '1 : '0;
      default:      return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // one frame: rows of pixels (cut short if cut is set), then flush ticks
  // to the end of the current row, which returns the block to row zero
  task automatic run_frame(int w_cfg, int h, int bf, int be, int rows, int cut,
                           bit noise, fill_e fill, int stall);
    int w;
    int total;
    int k;
    logic cmd;
    w = (w_cfg < 1) ? 1 : (w_cfg > LINE_DEPTH) ? LINE_DEPTH : w_cfg;
    total = rows * w;
    if (cut > 0 && cut < total) total = cut;
    drain();
    set_geometry(w_cfg, h, bf, be);
    hold_len = stall;
    for (k = 0; k < total; k++) begin
      cmd = (noise && $urandom_range(0, 15) == 0) ? CMD_FLUSH : CMD_PIXEL;
      push_word(cmd, pick_red(fill, k / w, k % w));
    end
    for (k = total % w; k < w; k++) push_word(CMD_FLUSH, PIX_W'($urandom));
  endtask

  initial begin : stimulus
    int sel;
    int w_cfg;
    int w_eff;
    int h;
    int bf;
    int be;
    int rows;
    int cut;
    bit noise;
    fill_e fill;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // small checkerboard frame, saturating magnitudes
    run_frame(3, 2, 0, 2, 2, 0, 1'b0, FILL_CHECKER, 0);

    // width shrinks mid row, flush inside a row, a row past the image
    drain();
    set_geometry(5, 2, 0, 2048);
    push_word(CMD_PIXEL, '1);
    push_word(CMD_PIXEL, '0);
    push_word(CMD_PIXEL, '1);
    push_word(CMD_PIXEL, 8'h81);
    drain();
    cfg_beat(CFG_IMAGE_WIDTH, 2);
    cfg_valid_i <= 1'b0;
    push_word(CMD_PIXEL, 8'h7e);
    push_word(CMD_FLUSH, 8'hff);
    push_word(CMD_PIXEL, 8'h3c);
    push_word(CMD_PIXEL, 8'hc3);
    push_word(CMD_PIXEL, 8'h55);
    push_word(CMD_FLUSH, 8'haa);
    push_word(CMD_FLUSH, 8'h0f);

    // empty band
    run_frame(2, 2, 1, 1, 2, 0, 1'b0, FILL_EXTREME, 0);

    items_sent = 0;
    // receiver holds off long enough for the result queue to back up
    run_frame(20, 6, 0, 6, 6, 0, 1'b0, FILL_RANDOM, 150);

    while (items_sent < RANDOM_ITEMS) begin
      gaps_on = (items_sent < RANDOM_ITEMS - CALM_ITEMS);
      sel = $urandom_range(0, 9);
      w_cfg = (sel == 0) ? 0 : (sel <= 3) ? sel : $urandom_range(4, 24);
      w_eff = (w_cfg < 1) ? 1 : w_cfg;
      h = $urandom_range(1, 6);
      if ($urandom_range(0, 1)) begin
        bf = 0;
        be = $urandom_range(0, 1) ? h : 2048;
      end else begin
        bf = $urandom_range(0, h + 1);
        be = $urandom_range(1, h + 2);
      end
      rows = h + $urandom_range(0, 1);
      cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, rows * w_eff) : 0;
      noise = ($urandom_range(0, 3) == 0);
      fill = fill_e'($urandom_range(0, 2));
      run_frame(w_cfg, h, bf, be, rows, cut, noise, fill, 0);
    end

    gaps_on = 1'b0;
    drain();
    if (sb.fails == 0)
      $display("** sobel_edge_magnitude: PASSED **");
    else
      $display("** sobel_edge_magnitude: FAILED **");
    $finish;
  end

endmodule
